### rtl/wsa_pkg.sv
package wsa_pkg;

  // event codes
  localparam logic [1:0] OP_BUTTON  = 2'd0;
  localparam logic [1:0] OP_REFRESH = 2'd1;
  localparam logic [1:0] OP_EXPIRY  = 2'd2;

  // button codes, also the slot of each button's last press time
  localparam logic [1:0] BTN_SELECT = 2'd0;
  localparam logic [1:0] BTN_INCR   = 2'd1;
  localparam logic [1:0] BTN_MODE   = 2'd2;
  localparam logic [1:0] BTN_ALARM  = 2'd3;

  // edit positions
  localparam logic [3:0] EDIT_HOUR     = 4'd0;
  localparam logic [3:0] EDIT_MINUTE   = 4'd1;
  localparam logic [3:0] EDIT_WEEKDAY  = 4'd2;
  localparam logic [3:0] EDIT_MONTH    = 4'd3;
  localparam logic [3:0] EDIT_DAY      = 4'd4;
  localparam logic [3:0] EDIT_YEAR     = 4'd5;
  localparam logic [3:0] EDIT_ALARM_ON = 4'd6;
  localparam logic [3:0] EDIT_ALARM_HR = 4'd7;
  localparam logic [3:0] EDIT_ALARM_MN = 4'd8;
  localparam logic [3:0] EDIT_NONE     = 4'd9;

  // configuration register indexes
  localparam logic CFG_PRESS_GAP  = 1'b0;
  localparam logic CFG_ADJUST_GAP = 1'b1;

  localparam logic [15:0] PRESS_GAP_RESET  = 16'd1000;
  localparam logic [15:0] ADJUST_GAP_RESET = 16'd10000;

  // year is held as an offset from the base year
  localparam logic [11:0] YEAR_BASE    = 12'd2000;
  localparam logic [6:0]  YEAR_OFF_MAX = 7'd99;
  localparam logic [6:0]  YEAR_OFF_CENTURY = 7'd100;

  localparam int unsigned STAMP_W = 27;

  // one accepted event word
  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         button;
    logic               pin_high;
    logic [STAMP_W-1:0] now_ms;
    logic [4:0]         clock_hour;
    logic [5:0]         clock_minute;
    logic [2:0]         clock_weekday;
    logic [4:0]         clock_day;
    logic [3:0]         clock_month;
    logic [6:0]         clock_year_offset;
  } event_t;

  // held watch state
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [2:0] weekday;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year_off;
    logic [4:0] wake_hour;
    logic [5:0] wake_minute;
    logic       wake_enabled;
    logic       adjust;
    logic [3:0] edit;
    logic       ringing;
    logic       silenced;
    logic       hold_armed;
  } watch_t;

  // press time check request to the debounce unit
  typedef struct packed {
    logic [1:0]         slot;
    logic [15:0]        gap;
    logic [STAMP_W-1:0] now_ms;
  } press_req_t;

  // days in a month, leap years by the gregorian rule; bad months get 31
  function automatic logic [4:0] month_days(input logic [3:0] month,
                                            input logic [6:0] year_off);
    logic leap;
    leap = (year_off[1:0] == 2'b00) && (year_off != YEAR_OFF_CENTURY);
    case (month)
      4'd4, 4'd6, 4'd9, 4'd11: month_days = 5'd30;
      4'd2:                    month_days = leap ? 5'd29 : 5'd28;
      default:                 month_days = 5'd31;
    endcase
  endfunction

endpackage

### rtl/wsa_debounce.sv
module wsa_debounce (
  input  logic                clk,
  input  logic                rst,
  input  wsa_pkg::press_req_t req,
  input  logic                stamp_we,
  output logic                gap_ok
);
  import wsa_pkg::*;

  logic [STAMP_W-1:0] last_press [4];
  logic [STAMP_W:0]   diff;

  // times are below 2^27, so a wrapped difference is always past any gap
  assign diff   = {1'b0, req.now_ms} - {1'b0, last_press[req.slot]};
  assign gap_ok = diff[STAMP_W] || (diff[STAMP_W-1:0] >= {{(STAMP_W-16){1'b0}}, req.gap});

  // last accepted press time per button
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) last_press[i] <= '0;
    end else if (stamp_we) begin
      last_press[req.slot] <= req.now_ms;
    end
  end

endmodule

### rtl/wsa_core.sv
module wsa_core (
  input  logic                clk,
  input  logic                rst,
  input  wsa_pkg::event_t     ev,
  input  logic                fire,
  input  logic [15:0]         press_gap_ms,
  input  logic [15:0]         adjust_gap_ms,
  input  logic                gap_ok,
  output wsa_pkg::press_req_t req,
  output logic                stamp_we,
  output wsa_pkg::watch_t     st_next
);
  import wsa_pkg::*;

  watch_t     st;
  logic       stamp;
  logic [4:0] ld_days;
  logic [5:0] rearm_minute;
  logic [4:0] rearm_hour;

  // debounce slot and gap for this word
  always_comb begin
    req.slot   = (ev.op == OP_EXPIRY) ? BTN_MODE : ev.button;
    req.gap    = (ev.op == OP_BUTTON && ev.button == BTN_INCR) ? adjust_gap_ms
                                                                 : press_gap_ms;
    req.now_ms = ev.now_ms;
  end

  assign stamp_we = fire && stamp;

  assign ld_days = month_days(ev.clock_month, ev.clock_year_offset);

  // alarm re-arm time, one minute after the alarm time
  always_comb begin
    if (st.wake_minute >= 6'd59) begin
      rearm_minute = 6'd0;
      rearm_hour   = (st.wake_hour >= 5'd23) ? 5'd0 : st.wake_hour + 5'd1;
    end else begin
      rearm_minute = st.wake_minute + 6'd1;
      rearm_hour   = st.wake_hour;
    end
  end

  // next state for the word in the input register
  always_comb begin
    st_next = st;
    stamp   = 1'b0;
    case (ev.op)
      OP_BUTTON: begin
        if (st.ringing) begin
          st_next.ringing  = 1'b0;
          st_next.silenced = 1'b1;
        end
        case (ev.button)
          BTN_ALARM: begin
            if (!st.adjust && gap_ok && ev.pin_high) begin
              stamp                = 1'b1;
              st_next.wake_enabled = !st.wake_enabled;
            end
          end
          BTN_MODE: begin
            if (gap_ok && ev.pin_high) begin
              stamp              = 1'b1;
              st_next.hold_armed = 1'b1;
            end
          end
          BTN_INCR: begin
            if (gap_ok && ev.pin_high && st.adjust) begin
              stamp = 1'b1;
              case (st.edit)
                EDIT_HOUR:     st_next.hour = (st.hour >= 5'd23) ? 5'd0 : st.hour + 5'd1;
                EDIT_MINUTE:   st_next.minute = (st.minute >= 6'd59) ? 6'd0
                                                                     : st.minute + 6'd1;
                EDIT_WEEKDAY:  st_next.weekday = (st.weekday >= 3'd6) ? 3'd0
                                                                      : st.weekday + 3'd1;
                EDIT_MONTH:    st_next.month = (st.month >= 4'd12) ? 4'd1 : st.month + 4'd1;
                EDIT_DAY:      st_next.day = (st.day >= month_days(st.month, st.year_off))
                                             ? 5'd1 : st.day + 5'd1;
                EDIT_YEAR:     st_next.year_off = (st.year_off >= YEAR_OFF_MAX) ? 7'd0
                                                                             : st.year_off + 7'd1;
                EDIT_ALARM_ON: st_next.wake_enabled = !st.wake_enabled;
                EDIT_ALARM_HR: st_next.wake_hour = (st.wake_hour >= 5'd23) ? 5'd0
                                                                           : st.wake_hour + 5'd1;
                EDIT_ALARM_MN: st_next.wake_minute = (st.wake_minute >= 6'd59) ? 6'd0
                                                                   : st.wake_minute + 6'd1;
                default: ;
              endcase
            end
          end
          default: begin
            if (gap_ok && ev.pin_high) begin
              stamp = 1'b1;
              if (st.adjust) begin
                st_next.edit = (st.edit >= EDIT_NONE) ? EDIT_HOUR : st.edit + 4'd1;
              end
            end
          end
        endcase
      end
      OP_REFRESH: begin
        if (!st.adjust) begin
          st_next.hour     = ev.clock_hour;
          st_next.minute   = ev.clock_minute;
          st_next.weekday  = ev.clock_weekday;
          st_next.day      = ev.clock_day;
          st_next.month    = ev.clock_month;
          st_next.year_off = ev.clock_year_offset;
          // roll an impossible day into the next month
          if (ev.clock_day > ld_days) begin
            st_next.day = 5'd1;
            if (ev.clock_month >= 4'd12) begin
              st_next.month    = 4'd1;
              st_next.year_off = (ev.clock_year_offset >= YEAR_OFF_MAX) ? 7'd0
                                 : ev.clock_year_offset + 7'd1;
            end else begin
              st_next.month = ev.clock_month + 4'd1;
            end
          end
          // alarm start and re-arm
          if (st.wake_enabled && !st.silenced && !st.ringing &&
              ev.clock_hour == st.wake_hour && ev.clock_minute == st.wake_minute) begin
            st_next.ringing = 1'b1;
          end
          if (st.silenced && ev.clock_hour == rearm_hour &&
              ev.clock_minute == rearm_minute) begin
            st_next.silenced = 1'b0;
          end
        end
      end
      OP_EXPIRY: begin
        if (st.hold_armed && ev.pin_high && gap_ok) begin
          st_next.adjust     = !st.adjust;
          st_next.edit       = EDIT_HOUR;
          st_next.hold_armed = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // held state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.hour         <= 5'd0;
      st.minute       <= 6'd0;
      st.weekday      <= 3'd0;
      st.day          <= 5'd1;
      st.month        <= 4'd1;
      st.year_off     <= 7'd0;
      st.wake_hour    <= 5'd8;
      st.wake_minute  <= 6'd0;
      st.wake_enabled <= 1'b1;
      st.adjust       <= 1'b0;
      st.edit         <= EDIT_HOUR;
      st.ringing      <= 1'b0;
      st.silenced     <= 1'b0;
      st.hold_armed   <= 1'b0;
    end else if (fire) begin
      st <= st_next;
    end
  end

endmodule

### rtl/watch_set_and_alarm_controller_top.sv
// Watch time-set and alarm controller. Each event word (button edge, display
// refresh with a clock reading, or hold timer expiry) gives exactly one result
// word with the held time, date, alarm settings and mode flags after it. An
// event passes an input register, combinational update logic and a result
// register, so the block takes one event per clock unless the result stalls,
// and a result word is valid once the result register holds it; while a result
// waits, one more event is held in the input register and then the input
// stalls. Button presses are debounced against the last accepted press of the
// same button using the two gap registers, which the user must write through
// the cfg port only while no event is in flight; the block does not enforce it.
module watch_set_and_alarm_controller_top (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // event channel
  input  logic        event_valid,
  output logic        event_stall,
  input  logic [1:0]  op,
  input  logic [1:0]  button,
  input  logic        pin_high,
  input  logic [26:0] now_ms,
  input  logic [4:0]  clock_hour,
  input  logic [5:0]  clock_minute,
  input  logic [2:0]  clock_weekday,
  input  logic [4:0]  clock_day,
  input  logic [3:0]  clock_month,
  input  logic [6:0]  clock_year_offset,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [4:0]  show_hour,
  output logic [5:0]  show_minute,
  output logic [2:0]  show_weekday,
  output logic [4:0]  show_day,
  output logic [3:0]  show_month,
  output logic [11:0] show_year,
  output logic [4:0]  show_alarm_hour,
  output logic [5:0]  show_alarm_minute,
  output logic        alarm_enabled,
  output logic        in_adjust,
  output logic [3:0]  edit_position,
  output logic        alarm_sounding
);
  import wsa_pkg::*;

  logic [15:0] press_gap_ms;
  logic [15:0] adjust_gap_ms;
  event_t      ev_q;
  logic        ev_valid;
  watch_t      res_q;
  logic        advance;
  logic        fire;
  logic        accept;
  press_req_t  req;
  logic        stamp_we;
  logic        gap_ok;
  watch_t      st_next;

  // gap registers
  always_ff @(posedge clk) begin
    if (rst) begin
      press_gap_ms  <= PRESS_GAP_RESET;
      adjust_gap_ms <= ADJUST_GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRESS_GAP:  press_gap_ms  <= cfg_data;
        CFG_ADJUST_GAP: adjust_gap_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign advance     = !result_valid || !result_stall;
  assign fire        = ev_valid && advance;
  assign event_stall = ev_valid && !advance;
  assign accept      = event_valid && !event_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (accept) begin
      ev_valid <= 1'b1;
    end else if (fire) begin
      ev_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev_q.op                <= op;
      ev_q.button            <= button;
      ev_q.pin_high          <= pin_high;
      ev_q.now_ms            <= now_ms;
      ev_q.clock_hour        <= clock_hour;
      ev_q.clock_minute      <= clock_minute;
      ev_q.clock_weekday     <= clock_weekday;
      ev_q.clock_day         <= clock_day;
      ev_q.clock_month       <= clock_month;
      ev_q.clock_year_offset <= clock_year_offset;
    end
  end

  wsa_debounce u_debounce (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .stamp_we (stamp_we),
    .gap_ok   (gap_ok)
  );

  wsa_core u_core (
    .clk           (clk),
    .rst           (rst),
    .ev            (ev_q),
    .fire          (fire),
    .press_gap_ms  (press_gap_ms),
    .adjust_gap_ms (adjust_gap_ms),
    .gap_ok        (gap_ok),
    .req           (req),
    .stamp_we      (stamp_we),
    .st_next       (st_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= st_next;
    end
  end

  // result word fields
  assign show_hour         = res_q.hour;
  assign show_minute       = res_q.minute;
  assign show_weekday      = res_q.weekday;
  assign show_day          = res_q.day;
  assign show_month        = res_q.month;
  assign show_year         = YEAR_BASE + {5'b0, res_q.year_off};
  assign show_alarm_hour   = res_q.wake_hour;
  assign show_alarm_minute = res_q.wake_minute;
  assign alarm_enabled     = res_q.wake_enabled;
  assign in_adjust         = res_q.adjust;
  assign edit_position     = res_q.edit;
  assign alarm_sounding    = res_q.ringing;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import wsa_pkg::*;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned DAY_MS      = 86400000;
  localparam int unsigned YEAR_FIRST  = 2000;
  localparam int unsigned YEAR_LAST   = 2099;
  localparam int unsigned QUIET_LIMIT = 2000;

  // one result word as the watch shows it
  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  weekday;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
    logic        alarm_on;
    logic        adjust;
    logic [3:0]  edit;
    logic        sounding;
  } watch_face_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        event_valid = 1'b0;
  logic        event_stall;
  event_t      word_in = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [4:0]  show_hour;
  logic [5:0]  show_minute;
  logic [2:0]  show_weekday;
  logic [4:0]  show_day;
  logic [3:0]  show_month;
  logic [11:0] show_year;
  logic [4:0]  show_alarm_hour;
  logic [5:0]  show_alarm_minute;
  logic        alarm_enabled;
  logic        in_adjust;
  logic [3:0]  edit_position;
  logic        alarm_sounding;

  watch_set_and_alarm_controller_top DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .event_valid(event_valid), .event_stall(event_stall),
    .op(word_in.op), .button(word_in.button), .pin_high(word_in.pin_high),
    .now_ms(word_in.now_ms), .clock_hour(word_in.clock_hour),
    .clock_minute(word_in.clock_minute), .clock_weekday(word_in.clock_weekday),
    .clock_day(word_in.clock_day), .clock_month(word_in.clock_month),
    .clock_year_offset(word_in.clock_year_offset),
    .result_valid(result_valid), .result_stall(result_stall),
    .show_hour(show_hour), .show_minute(show_minute), .show_weekday(show_weekday),
    .show_day(show_day), .show_month(show_month), .show_year(show_year),
    .show_alarm_hour(show_alarm_hour), .show_alarm_minute(show_alarm_minute),
    .alarm_enabled(alarm_enabled), .in_adjust(in_adjust),
    .edit_position(edit_position), .alarm_sounding(alarm_sounding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // predicted watch state and gap settings
  int unsigned gap_press = 32'(PRESS_GAP_RESET);
  int unsigned gap_incr  = 32'(ADJUST_GAP_RESET);
  logic [3:0]  s_edit;
  int unsigned s_hour, s_minute, s_wday, s_day, s_month, s_year;
  int unsigned s_whour, s_wmin;
  int unsigned s_last [4];
  bit          s_adjust, s_wake_on, s_ringing, s_silenced, s_armed;

  watch_face_t faces_due [$];
  int unsigned mismatches = 0;
  int unsigned sent = 0;
  int unsigned stamp = 20000000;
  int unsigned burst_left = 0;
  bit          sender_live = 1'b0;
  int unsigned quiet = 0;

  function automatic int unsigned days_of_month(int unsigned month, int unsigned year);
    if (month == 4 || month == 6 || month == 9 || month == 11) return 30;
    if (month == 2)
      return ((year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0))) ? 29 : 28;
    return 31;
  endfunction

  // modular millisecond spacing against the last accepted press of a button
  function automatic bit press_spaced(logic [1:0] slot, int unsigned now, int unsigned gap);
    int unsigned span;
    span = now - s_last[slot];
    return span >= gap;
  endfunction

  task automatic bump_selected_field;
    case (s_edit)
      EDIT_HOUR:     begin s_hour++; if (s_hour >= 24) s_hour = 0; end
      EDIT_MINUTE:   begin s_minute++; if (s_minute >= 60) s_minute = 0; end
      EDIT_WEEKDAY:  begin s_wday++; if (s_wday > 6) s_wday = 0; end
      EDIT_MONTH:    begin s_month++; if (s_month > 12) s_month = 1; end
      EDIT_DAY:      begin s_day++; if (s_day > days_of_month(s_month, s_year)) s_day = 1; end
      EDIT_YEAR:     begin s_year++; if (s_year > YEAR_LAST) s_year = YEAR_FIRST; end
      EDIT_ALARM_ON: s_wake_on ^= 1'b1;
      EDIT_ALARM_HR: begin s_whour++; if (s_whour >= 24) s_whour = 0; end
      EDIT_ALARM_MN: begin s_wmin++; if (s_wmin >= 60) s_wmin = 0; end
      default: ;
    endcase
  endtask

  // state update for one accepted word, giving the face it should show
  task automatic advance_watch(input event_t w, output watch_face_t f);
    int unsigned now, nh, nm;
    now = 32'(w.now_ms);
    case (w.op)
      OP_BUTTON: begin
        if (s_ringing) begin
          s_ringing = 1'b0;
          s_silenced = 1'b1;
        end
        case (w.button)
          BTN_ALARM:
            if (!s_adjust && press_spaced(BTN_ALARM, now, gap_press) && w.pin_high) begin
              s_last[BTN_ALARM] = now;
              s_wake_on ^= 1'b1;
            end
          BTN_MODE:
            if (press_spaced(BTN_MODE, now, gap_press) && w.pin_high) begin
              s_last[BTN_MODE] = now;
              s_armed = 1'b1;
            end
          BTN_INCR:
            if (press_spaced(BTN_INCR, now, gap_incr) && w.pin_high && s_adjust) begin
              s_last[BTN_INCR] = now;
              bump_selected_field();
            end
          default:
            if (press_spaced(BTN_SELECT, now, gap_press) && w.pin_high) begin
              s_last[BTN_SELECT] = now;
              if (s_adjust) begin
                s_edit++;
                if (s_edit > EDIT_NONE) s_edit = EDIT_HOUR;
              end
            end
        endcase
      end
      OP_REFRESH:
        if (!s_adjust) begin
          s_hour = 32'(w.clock_hour);
          s_minute = 32'(w.clock_minute);
          s_wday = 32'(w.clock_weekday);
          s_day = 32'(w.clock_day);
          s_month = 32'(w.clock_month);
          s_year = YEAR_FIRST + 32'(w.clock_year_offset);
          // impossible day rolls into the next month
          if (s_day > days_of_month(s_month, s_year)) begin
            s_day = 1;
            s_month++;
            if (s_month > 12) begin
              s_month = 1;
              s_year++;
              if (s_year > YEAR_LAST) s_year = YEAR_FIRST;
            end
          end
          if (s_wake_on && !s_silenced && !s_ringing && s_hour == s_whour &&
              s_minute == s_wmin)
            s_ringing = 1'b1;
          // a silenced alarm re-arms one minute after the alarm time
          nm = s_wmin + 1;
          nh = s_whour;
          if (nm >= 60) begin
            nm = 0;
            nh++;
            if (nh >= 24) nh = 0;
          end
          if (s_silenced && s_hour == nh && s_minute == nm) s_silenced = 1'b0;
        end
      OP_EXPIRY:
        if (s_armed && w.pin_high && press_spaced(BTN_MODE, now, gap_press)) begin
          s_adjust ^= 1'b1;
          s_edit = EDIT_HOUR;
          s_armed = 1'b0;
        end
      default: ;
    endcase
    f.hour = s_hour[4:0];
    f.minute = s_minute[5:0];
    f.weekday = s_wday[2:0];
    f.day = s_day[4:0];
    f.month = s_month[3:0];
    f.year = s_year[11:0];
    f.alarm_hour = s_whour[4:0];
    f.alarm_minute = s_wmin[5:0];
    f.alarm_on = s_wake_on;
    f.adjust = s_adjust;
    f.edit = s_edit[3:0];
    f.sounding = s_ringing;
  endtask

  // receiver stall pattern: free running, random, or runs of stall
  int unsigned stall_mode = 0;
  int unsigned stall_run = 0;
  int unsigned stall_cycles = 0;
  bit          stall_level = 1'b0;
  always @(posedge clk) begin
    stall_cycles++;
    if (stall_cycles % 150 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_run != 0) begin
          stall_run--;
        end else begin
          stall_run = $urandom_range(0, 6);
          stall_level = !stall_level;
        end
        result_stall <= stall_level;
      end
    endcase
  end

  task automatic check_field(string label, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
      mismatches++;
    end
  endtask

  // result checking against the oldest predicted face
  always @(posedge clk) begin : check_results
    watch_face_t want;
    if (!rst && result_valid && !result_stall) begin
      if (faces_due.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        mismatches++;
      end else begin
        want = faces_due.pop_front();
        check_field("show_hour", 12'(want.hour), 12'(show_hour));
        check_field("show_minute", 12'(want.minute), 12'(show_minute));
        check_field("show_weekday", 12'(want.weekday), 12'(show_weekday));
        check_field("show_day", 12'(want.day), 12'(show_day));
        check_field("show_month", 12'(want.month), 12'(show_month));
        check_field("show_year", want.year, show_year);
        check_field("show_alarm_hour", 12'(want.alarm_hour), 12'(show_alarm_hour));
        check_field("show_alarm_minute", 12'(want.alarm_minute), 12'(show_alarm_minute));
        check_field("alarm_enabled", 12'(want.alarm_on), 12'(alarm_enabled));
        check_field("in_adjust", 12'(want.adjust), 12'(in_adjust));
        check_field("edit_position", 12'(want.edit), 12'(edit_position));
        check_field("alarm_sounding", 12'(want.sounding), 12'(alarm_sounding));
      end
    end
  end

  // watchdog on cycles where no word moves
  always @(posedge clk) begin
    if (rst || (event_valid && !event_stall) || (result_valid && !result_stall))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // send one word, then keep the burst going or idle for a while
  task automatic send_word(input event_t w);
    watch_face_t f;
    int unsigned idle;
    word_in <= w;
    event_valid <= 1'b1;
    sender_live = 1'b1;
    do @(posedge clk); while (event_stall);
    advance_watch(w, f);
    faces_due.push_back(f);
    sent++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (idle != 0) begin
        event_valid <= 1'b0;
        sender_live = 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained;
    if (sender_live) begin
      event_valid <= 1'b0;
      sender_live = 1'b0;
    end
    while (faces_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_gaps(input logic [15:0] press_gap, input logic [15:0] incr_gap);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= CFG_PRESS_GAP;
    cfg_data <= press_gap;
    @(posedge clk);
    gap_press = 32'(press_gap);
    cfg_index <= CFG_ADJUST_GAP;
    cfg_data <= incr_gap;
    @(posedge clk);
    gap_incr = 32'(incr_gap);
    cfg_we <= 1'b0;
  endtask

  function automatic void tick(int unsigned ms);
    stamp = (stamp + ms) % DAY_MS;
  endfunction

  // mostly far enough past the gap, now and then too early
  function automatic void tick_for(int unsigned gap);
    if ($urandom_range(0, 9) == 0) tick($urandom_range(0, gap));
    else tick(gap + $urandom_range(1, 1500));
  endfunction

  // word at the current stamp; clock fields random over their full width
  function automatic event_t make_word(logic [1:0] op_code, logic [1:0] btn, logic pin);
    event_t w;
    w.op = op_code;
    w.button = btn;
    w.pin_high = pin;
    w.now_ms = stamp[26:0];
    w.clock_hour = 5'($urandom_range(0, 31));
    w.clock_minute = 6'($urandom_range(0, 63));
    w.clock_weekday = 3'($urandom_range(0, 7));
    w.clock_day = 5'($urandom_range(0, 31));
    w.clock_month = 4'($urandom_range(0, 15));
    w.clock_year_offset = 7'($urandom_range(0, 127));
    return w;
  endfunction

  task automatic press(input logic [1:0] btn, input logic pin);
    send_word(make_word(OP_BUTTON, btn, pin));
  endtask

  task automatic expire(input logic pin);
    send_word(make_word(OP_EXPIRY, 2'($urandom_range(0, 3)), pin));
  endtask

  task automatic refresh(input int unsigned h, m, wd, d, mo, yo);
    event_t w;
    w = make_word(OP_REFRESH, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    w.clock_hour = h[4:0];
    w.clock_minute = m[5:0];
    w.clock_weekday = wd[2:0];
    w.clock_day = d[4:0];
    w.clock_month = mo[3:0];
    w.clock_year_offset = yo[6:0];
    send_word(w);
  endtask

  task automatic refresh_at(input int unsigned h, m);
    refresh(h, m, $urandom_range(0, 6), $urandom_range(1, 28), $urandom_range(1, 12),
            $urandom_range(0, 99));
  endtask

  // mode press then hold expiry; the rough form mixes in failed expiries
  task automatic flip_adjust(input bit rough);
    bit was;
    was = s_adjust;
    if (rough) begin
      tick_for(gap_press);
      press(BTN_MODE, $urandom_range(0, 7) != 0);
      if ($urandom_range(0, 3) == 0) begin
        tick($urandom_range(0, gap_press));
        expire(1'($urandom_range(0, 1)));
      end
      tick(gap_press + $urandom_range(0, 400));
      expire($urandom_range(0, 7) != 0);
    end else begin
      while (s_adjust == was) begin
        tick(gap_press + $urandom_range(1, 400));
        press(BTN_MODE, 1'b1);
        tick(gap_press + $urandom_range(1, 400));
        expire(1'b1);
      end
    end
  endtask

  task automatic goto_edit(input logic [3:0] pos);
    while (s_edit != pos) begin
      tick(gap_press + $urandom_range(1, 300));
      press(BTN_SELECT, 1'b1);
    end
  endtask

  task automatic bump(input int unsigned n);
    repeat (n) begin
      tick(gap_incr + $urandom_range(1, 300));
      press(BTN_INCR, 1'b1);
    end
  endtask

  // select and increment presses inside adjust mode, with a stray refresh, alarm press or expiry
  task automatic edit_session;
    int unsigned pick;
    if (!s_adjust) flip_adjust(1'b1);
    repeat ($urandom_range(3, 20)) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        tick_for(gap_press);
        press(BTN_SELECT, $urandom_range(0, 7) != 0);
      end else if (pick < 9) begin
        tick_for(gap_incr);
        press(BTN_INCR, $urandom_range(0, 7) != 0);
      end else begin
        tick($urandom_range(0, 3000));
        case ($urandom_range(0, 2))
          0: refresh_at($urandom_range(0, 23), $urandom_range(0, 59));
          1: press(BTN_ALARM, 1'b1);
          default: expire(1'($urandom_range(0, 1)));
        endcase
      end
    end
    if (s_adjust) flip_adjust(1'($urandom_range(0, 1)));
  endtask

  // ring at the alarm time, silence, then re-arm one minute later
  task automatic alarm_round;
    int unsigned nh, nm;
    if (s_adjust) flip_adjust(1'b0);
    if ($urandom_range(0, 3) == 0) begin
      tick_for(gap_press);
      press(BTN_ALARM, 1'b1);
    end
    tick($urandom_range(0, 500));
    refresh_at(s_whour, s_wmin);
    if ($urandom_range(0, 1)) refresh_at(s_whour, s_wmin);
    tick_for(gap_press);
    press(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    refresh_at(s_whour, s_wmin);
    nm = s_wmin + 1;
    nh = s_whour;
    if (nm >= 60) begin
      nm = 0;
      nh = (nh + 1) % 24;
    end
    refresh_at(nh, nm);
  endtask

  task automatic noise_burst;
    event_t w;
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 5))
        0: stamp = $urandom_range(0, DAY_MS - 1);
        1: stamp = DAY_MS - 1 - $urandom_range(0, 20000);
        default: tick($urandom_range(0, 3000));
      endcase
      w = make_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                    1'($urandom_range(0, 1)));
      send_word(w);
    end
  endtask

  task automatic refresh_burst;
    repeat ($urandom_range(1, 6)) begin
      tick($urandom_range(0, 60000));
      if ($urandom_range(0, 4) == 0)
        send_word(make_word(OP_REFRESH, 2'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1))));
      else
        refresh($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 6),
                $urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(0, 99));
    end
  endtask

  // unknown op, expiry with nothing armed, a released alarm button
  task automatic test_idle_words;
    send_word(make_word(OP_UNUSED, BTN_SELECT, 1'b1));
    tick(gap_press + 1);
    expire(1'b1);
    tick(gap_press + 1);
    press(BTN_ALARM, 1'b0);
  endtask

  // clock loads: plain, out of range, leap and non-leap february, short month
  task automatic test_clock_load;
    refresh(12, 34, 3, 15, 6, 23);
    refresh(31, 63, 7, 0, 15, 127);
    refresh(7, 59, 6, 30, 2, 0);
    refresh(7, 59, 6, 29, 2, 100);
    refresh(7, 59, 5, 31, 4, 98);
  endtask

  task automatic test_alarm_cycle;
    refresh(8, 0, 0, 1, 1, 24);
    tick(200);
    press(BTN_SELECT, 1'b0);
    refresh(8, 0, 0, 1, 1, 24);
    refresh(8, 1, 0, 1, 1, 24);
    tick(gap_press + 1);
    press(BTN_ALARM, 1'b1);
  endtask

  // enter adjust after a failed expiry, refresh ignored, hour and year wrap
  task automatic test_adjust_edit;
    refresh(23, 0, 2, 10, 3, 99);
    tick(gap_press + 1);
    press(BTN_MODE, 1'b1);
    tick(gap_press + 1);
    expire(1'b0);
    tick(5);
    expire(1'b1);
    refresh(1, 2, 3, 4, 5, 6);
    tick(gap_incr + 1);
    press(BTN_INCR, 1'b1);
    repeat (5) begin
      tick(gap_press + 1);
      press(BTN_SELECT, 1'b1);
    end
    tick(gap_incr + 1);
    press(BTN_INCR, 1'b1);
  endtask

  // alarm set to 23:59 so that the re-arm carries into midnight
  task automatic test_alarm_rollover;
    if (!s_adjust) flip_adjust(1'b0);
    goto_edit(EDIT_ALARM_ON);
    if (!s_wake_on) bump(1);
    goto_edit(EDIT_ALARM_HR);
    bump((23 + 24 - s_whour) % 24);
    goto_edit(EDIT_ALARM_MN);
    bump((59 + 60 - s_wmin) % 60);
    flip_adjust(1'b0);
    refresh_at(23, 59);
    tick(gap_press + 1);
    press(BTN_SELECT, 1'b1);
    refresh_at(23, 59);
    refresh_at(0, 0);
    refresh_at(23, 59);
  endtask

  task automatic test_random_mix(input int unsigned count);
    int unsigned target;
    target = sent + count;
    while (sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: edit_session();
        5, 6:          alarm_round();
        7, 8:          noise_burst();
        default:       refresh_burst();
      endcase
    end
  endtask

  initial begin
    s_adjust = 1'b0;
    s_edit = EDIT_HOUR;
    s_hour = 0;
    s_minute = 0;
    s_wday = 0;
    s_day = 1;
    s_month = 1;
    s_year = YEAR_FIRST;
    s_whour = 8;
    s_wmin = 0;
    s_wake_on = 1'b1;
    s_ringing = 1'b0;
    s_silenced = 1'b0;
    s_armed = 1'b0;
    foreach (s_last[i]) s_last[i] = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_idle_words();
    test_clock_load();
    test_alarm_cycle();
    test_adjust_edit();

    write_gaps(16'd0, 16'd0);
    test_random_mix(115);
    write_gaps(16'hFFFF, 16'hFFFF);
    test_random_mix(115);
    write_gaps(PRESS_GAP_RESET, ADJUST_GAP_RESET);
    test_alarm_rollover();
    test_random_mix(115);
    write_gaps(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 20000)));
    test_random_mix(115);
    write_gaps(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    test_random_mix(115);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
